// File: rtl/huffman_code_builder_core_macros.svh
// ----------------------------------------------------------------------------
// huffman_code_builder_core_macros
// Assertion macros for the Huffman code builder.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcb assertion failed");

// Next-cycle implication, checked outside reset.
`define HCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcb assertion failed");

`endif

// File: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Types, sizes and command codes shared by the Huffman code builder modules.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int SYMBOLS      = 256;
  localparam int COUNT_BITS   = 32;
  localparam int MAX_CODE_LEN = 64;
  localparam int NODES        = 2 * SYMBOLS - 1;
  localparam int SYM_W        = $clog2(SYMBOLS);
  localparam int HCNT_W       = $clog2(SYMBOLS + 1);
  localparam int NODE_W       = $clog2(NODES);
  localparam int WEIGHT_W     = COUNT_BITS + SYM_W;
  localparam int CODE_W       = 64;
  localparam int LEN_W        = 7;
  localparam int DEPTH_W      = SYM_W;
  localparam int CIDX_W       = SYM_W + 2;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOCODE = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [7:0]        symbol;
    logic [31:0]       frequency;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [63:0]       code_bits;
    logic [6:0]        code_length;
  } out_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node;
  } heap_entry_t;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
  } child_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [CODE_W-1:0]  code;
  } walk_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } code_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_READ_RESP,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_EMPTY,
    OP_SINGLE,
    OP_HEAPIFY_INIT,
    OP_HEAPIFY_DEC,
    OP_HD_LD,
    OP_HD_V,
    OP_HD_RD,
    OP_HD_CMP,
    OP_POP_RD,
    OP_POP_V,
    OP_PUSH_INIT,
    OP_PUSH_RD,
    OP_PUSH_CMP,
    OP_WK_INIT,
    OP_WK_RD,
    OP_WK_L,
    OP_WK_R,
    OP_AS_INIT,
    OP_AS_RD,
    OP_AS_WR,
    OP_BUILD_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_END,
    S_HD_LD,
    S_HD_V,
    S_HD_RD,
    S_HD_CMP,
    S_HD_DEC,
    S_POP_RD,
    S_POP_V,
    S_PUSH_INIT,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_LOOP,
    S_WK_INIT,
    S_WK_RD,
    S_WK_L,
    S_WK_R,
    S_AS_INIT,
    S_AS_RD,
    S_AS_WR,
    S_DONE
  } state_t;

  // Which caller a sift-down returns to
  typedef enum logic [1:0] {
    PH_HEAPIFY,
    PH_POP_A,
    PH_POP_B
  } phase_t;

  typedef struct packed {
    dp_op_t op;
    logic   pop_to_b;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic scan_last;
    logic used_zero;
    logic used_one;
    logic hd_done;
    logic i_zero;
    logic push_done;
    logic n_one;
    logic wk_last;
    logic as_last;
  } sts_t;

endpackage

// File: rtl/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer: handshakes the input channel and steps the datapath through
// scan, heap build, merge loop, tree walk and code assignment.
// ----------------------------------------------------------------------------
module hcb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  hcb_pkg::func_t cmd_func,
  output logic          cmd_ready,
  input  hcb_pkg::sts_t sts,
  output hcb_pkg::cmd_t dp_cmd
);
  import hcb_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic   fire;

  assign cmd_ready = (state == S_IDLE) && !sts.out_busy;
  assign fire      = cmd_valid && cmd_ready;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_HEAPIFY;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      S_IDLE: begin
        if (fire) begin
          case (cmd_func)
            FUNC_BUILD: state_next = S_SCAN_RD;
            FUNC_READ:  state_next = S_READ;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_READ:     state_next = S_IDLE;
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: state_next = sts.scan_last ? S_SCAN_END : S_SCAN_RD;
      S_SCAN_END: begin
        if (sts.used_zero || sts.used_one) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_HD_LD;
          phase_next = PH_HEAPIFY;
        end
      end
      S_HD_LD: state_next = S_HD_V;
      S_HD_V:  state_next = S_HD_CMP;
      S_HD_RD: state_next = S_HD_CMP;
      S_HD_CMP: begin
        if (!sts.hd_done) begin
          state_next = S_HD_RD;
        end else begin
          case (phase)
            PH_HEAPIFY: begin
              if (sts.i_zero) begin
                state_next = S_POP_RD;
                phase_next = PH_POP_A;
              end else begin
                state_next = S_HD_DEC;
              end
            end
            PH_POP_A: begin
              state_next = S_POP_RD;
              phase_next = PH_POP_B;
            end
            default: state_next = S_PUSH_INIT;
          endcase
        end
      end
      S_HD_DEC:    state_next = S_HD_LD;
      S_POP_RD:    state_next = S_POP_V;
      S_POP_V:     state_next = S_HD_RD;
      S_PUSH_INIT: state_next = S_PUSH_RD;
      S_PUSH_RD:   state_next = S_PUSH_CMP;
      S_PUSH_CMP:  state_next = sts.push_done ? S_LOOP : S_PUSH_RD;
      S_LOOP: begin
        if (sts.n_one) begin
          state_next = S_WK_INIT;
        end else begin
          state_next = S_POP_RD;
          phase_next = PH_POP_A;
        end
      end
      S_WK_INIT: state_next = S_WK_RD;
      S_WK_RD:   state_next = S_WK_L;
      S_WK_L:    state_next = S_WK_R;
      S_WK_R:    state_next = sts.wk_last ? S_AS_INIT : S_WK_RD;
      S_AS_INIT: state_next = S_AS_RD;
      S_AS_RD:   state_next = S_AS_WR;
      S_AS_WR:   state_next = sts.as_last ? S_DONE : S_AS_RD;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    dp_cmd.op       = OP_NOP;
    dp_cmd.pop_to_b = (phase == PH_POP_B);
    case (state)
      S_IDLE:     dp_cmd.op = fire ? OP_ACCEPT : OP_NOP;
      S_READ:     dp_cmd.op = OP_READ_RESP;
      S_SCAN_RD:  dp_cmd.op = OP_SCAN_RD;
      S_SCAN_CHK: dp_cmd.op = OP_SCAN_CHK;
      S_SCAN_END: begin
        if (sts.used_zero)     dp_cmd.op = OP_EMPTY;
        else if (sts.used_one) dp_cmd.op = OP_SINGLE;
        else                   dp_cmd.op = OP_HEAPIFY_INIT;
      end
      S_HD_LD:     dp_cmd.op = OP_HD_LD;
      S_HD_V:      dp_cmd.op = OP_HD_V;
      S_HD_RD:     dp_cmd.op = OP_HD_RD;
      S_HD_CMP:    dp_cmd.op = OP_HD_CMP;
      S_HD_DEC:    dp_cmd.op = OP_HEAPIFY_DEC;
      S_POP_RD:    dp_cmd.op = OP_POP_RD;
      S_POP_V:     dp_cmd.op = OP_POP_V;
      S_PUSH_INIT: dp_cmd.op = OP_PUSH_INIT;
      S_PUSH_RD:   dp_cmd.op = OP_PUSH_RD;
      S_PUSH_CMP:  dp_cmd.op = OP_PUSH_CMP;
      S_LOOP:      dp_cmd.op = OP_NOP;
      S_WK_INIT:   dp_cmd.op = OP_WK_INIT;
      S_WK_RD:     dp_cmd.op = OP_WK_RD;
      S_WK_L:      dp_cmd.op = OP_WK_L;
      S_WK_R:      dp_cmd.op = OP_WK_R;
      S_AS_INIT:   dp_cmd.op = OP_AS_INIT;
      S_AS_RD:     dp_cmd.op = OP_AS_RD;
      S_AS_WR:     dp_cmd.op = OP_AS_WR;
      S_DONE:      dp_cmd.op = OP_BUILD_DONE;
      default:     dp_cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// Frequency store, min-heap, tree and code memories with their counters,
// plus the result register. Acts on one controller operation per cycle.
// ----------------------------------------------------------------------------
module hcb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  hcb_pkg::cmd_t       dp_cmd,
  input  hcb_pkg::in_item_t   cmd_item,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output hcb_pkg::out_item_t  rsp_item,
  output hcb_pkg::sts_t       sts
);
  import hcb_pkg::*;

  // Frequency store (valid bits give the all-zero reset)
  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [SYMBOLS-1:0]    cnt_vld;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  cnt_vld_q;

  // Heap, leaf symbols, children, walk data, code table
  heap_entry_t        heap_mem [SYMBOLS];
  heap_entry_t        ha_q, hb_q;
  logic [SYM_W-1:0]   sym_mem [SYMBOLS];
  logic [SYM_W-1:0]   sym_q;
  child_t             child_mem [NODES];
  child_t             child_q;
  walk_t              walk_mem [NODES];
  walk_t              walk_q;
  code_t              code_mem [SYMBOLS];
  code_t              code_q;
  logic [SYMBOLS-1:0] code_vld;
  logic               code_ok_q;
  logic               codes_ready;

  // Build registers
  logic [SYM_W-1:0]  scan_sym;
  logic [SYM_W-1:0]  last_sym;
  logic [HCNT_W-1:0] used;
  logic [HCNT_W-1:0] hcnt;
  logic [SYM_W-1:0]  hi;
  logic [SYM_W-1:0]  idx;
  heap_entry_t       v;
  heap_entry_t       a_ent, b_ent, new_ent;
  logic [HCNT_W-1:0] pi;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] k;
  child_t            wk_c;
  walk_t             wk_w;
  logic [SYM_W-1:0]  j;

  // Memory port controls
  logic              heap_we;
  logic [SYM_W-1:0]  heap_wa, heap_ra, heap_rb;
  heap_entry_t       heap_wd;
  logic              walk_we;
  logic [NODE_W-1:0] walk_wa, walk_ra;
  walk_t             walk_wd;
  logic              code_we;
  logic [SYM_W-1:0]  code_wa;
  code_t             code_wd;

  // Sift-down compare
  logic [CIDX_W-1:0]   l_idx, r_idx;
  logic                take_l, take_r, hd_done;
  logic [WEIGHT_W-1:0] min_w;
  logic [HCNT_W-1:0]   pi_m1, parent;
  logic                push_stop;
  logic [DEPTH_W-1:0]  d_inc;
  logic [CODE_W-1:0]   c_shl;

  // Result register
  logic      out_load;
  out_item_t out_next;

  logic is_write, is_build;
  assign is_write = (dp_cmd.op == OP_ACCEPT) && (cmd_item.func == FUNC_WRITE);
  assign is_build = (dp_cmd.op == OP_ACCEPT) && (cmd_item.func == FUNC_BUILD);

  // Heap child compare: strict less, left before right
  assign l_idx   = {1'b0, idx, 1'b1};
  assign r_idx   = l_idx + CIDX_W'(1);
  assign take_l  = (l_idx < CIDX_W'(hcnt)) && (ha_q.weight < v.weight);
  assign min_w   = take_l ? ha_q.weight : v.weight;
  assign take_r  = (r_idx < CIDX_W'(hcnt)) && (hb_q.weight < min_w);
  assign hd_done = !take_l && !take_r;

  // Sift-up compare
  assign pi_m1     = pi - HCNT_W'(1);
  assign parent    = pi_m1 >> 1;
  assign push_stop = (pi == '0) || !(new_ent.weight < ha_q.weight);

  assign d_inc = walk_q.depth + DEPTH_W'(1);
  assign c_shl = walk_q.code << 1;

  // Port muxes
  always_comb begin
    heap_we = 1'b0;
    heap_wa = idx;
    heap_wd = v;
    heap_ra = l_idx[SYM_W-1:0];
    heap_rb = r_idx[SYM_W-1:0];
    walk_we = 1'b0;
    walk_wa = wk_c.left;
    walk_wd = '0;
    walk_ra = k;
    code_we = 1'b0;
    code_wa = sym_q;
    code_wd = '0;
    case (dp_cmd.op)
      OP_SCAN_CHK: begin
        heap_we        = cnt_vld_q && (cnt_q != '0);
        heap_wa        = used[SYM_W-1:0];
        heap_wd.weight = WEIGHT_W'(cnt_q);
        heap_wd.node   = NODE_W'(used);
      end
      OP_HD_LD: heap_ra = hi;
      OP_HD_CMP: begin
        heap_we = 1'b1;
        heap_wa = idx;
        if (hd_done)     heap_wd = v;
        else if (take_r) heap_wd = hb_q;
        else             heap_wd = ha_q;
      end
      OP_POP_RD: begin
        // Root and last entry of the current heap
        heap_ra = '0;
        heap_rb = SYM_W'(hcnt - HCNT_W'(1));
      end
      OP_PUSH_RD: heap_ra = parent[SYM_W-1:0];
      OP_PUSH_CMP: begin
        heap_we = 1'b1;
        heap_wa = pi[SYM_W-1:0];
        heap_wd = push_stop ? new_ent : ha_q;
      end
      OP_WK_INIT: begin
        walk_we = 1'b1;
        walk_wa = next_node - NODE_W'(1);
        walk_wd = '0;
      end
      OP_WK_L: begin
        walk_we       = 1'b1;
        walk_wa       = child_q.left;
        walk_wd.depth = d_inc;
        walk_wd.code  = c_shl;
      end
      OP_WK_R: begin
        walk_we       = 1'b1;
        walk_wa       = wk_c.right;
        walk_wd.depth = wk_w.depth + DEPTH_W'(1);
        walk_wd.code  = (wk_w.code << 1) | CODE_W'(1);
      end
      OP_AS_RD: walk_ra = NODE_W'(j);
      OP_AS_WR: begin
        code_we      = (walk_q.depth <= DEPTH_W'(MAX_CODE_LEN));
        code_wa      = sym_q;
        code_wd.bits = walk_q.code;
        code_wd.len  = LEN_W'(walk_q.depth);
      end
      OP_SINGLE: begin
        code_we      = 1'b1;
        code_wa      = last_sym;
        code_wd.bits = '0;
        code_wd.len  = LEN_W'(1);
      end
      default: ;
    endcase
  end

  // Frequency memory
  always_ff @(posedge clk) begin
    if (is_write) cnt_mem[cmd_item.symbol] <= cmd_item.frequency;
    cnt_q <= cnt_mem[scan_sym];
  end

  // Heap memory, two read ports
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    ha_q <= heap_mem[heap_ra];
    hb_q <= heap_mem[heap_rb];
  end

  // Leaf symbol memory
  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_SCAN_CHK && cnt_vld_q && cnt_q != '0)
      sym_mem[used[SYM_W-1:0]] <= scan_sym;
    sym_q <= sym_mem[j];
  end

  // Child memory
  always_ff @(posedge clk) begin
    if (dp_cmd.op == OP_PUSH_INIT) begin
      child_mem[next_node] <= '{left: a_ent.node, right: b_ent.node};
    end
    child_q <= child_mem[k];
  end

  // Walk memory
  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    walk_q <= walk_mem[walk_ra];
  end

  // Code table
  always_ff @(posedge clk) begin
    if (code_we) code_mem[code_wa] <= code_wd;
    code_q    <= code_mem[cmd_item.symbol];
    code_ok_q <= code_vld[cmd_item.symbol];
  end

  // Valid bits and ready flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld     <= '0;
      code_vld    <= '0;
      codes_ready <= 1'b0;
    end else begin
      if (is_write) begin
        cnt_vld[cmd_item.symbol] <= 1'b1;
        codes_ready              <= 1'b0;
      end
      if (is_build) begin
        code_vld    <= '0;
        codes_ready <= 1'b0;
      end else if (code_we) begin
        code_vld[code_wa] <= 1'b1;
      end
      if (dp_cmd.op == OP_SINGLE || dp_cmd.op == OP_BUILD_DONE) codes_ready <= 1'b1;
    end
  end

  // Build counters and working registers
  always_ff @(posedge clk) begin
    cnt_vld_q <= cnt_vld[scan_sym];
    case (dp_cmd.op)
      OP_ACCEPT: begin
        scan_sym <= '0;
        used     <= '0;
      end
      OP_SCAN_CHK: begin
        if (cnt_vld_q && cnt_q != '0) begin
          used     <= used + HCNT_W'(1);
          last_sym <= scan_sym;
        end
        scan_sym <= scan_sym + SYM_W'(1);
      end
      OP_HEAPIFY_INIT: begin
        hcnt      <= used;
        hi        <= SYM_W'((used - HCNT_W'(2)) >> 1);
        next_node <= NODE_W'(used);
      end
      OP_HEAPIFY_DEC: hi <= hi - SYM_W'(1);
      OP_HD_LD:  idx <= hi;
      OP_HD_V:   v <= ha_q;
      OP_HD_CMP: begin
        if (!hd_done) idx <= take_r ? r_idx[SYM_W-1:0] : l_idx[SYM_W-1:0];
      end
      OP_POP_RD: pi <= hcnt;
      OP_POP_V: begin
        v    <= hb_q;
        hcnt <= hcnt - HCNT_W'(1);
        idx  <= '0;
        if (dp_cmd.pop_to_b) b_ent <= ha_q;
        else                 a_ent <= ha_q;
      end
      OP_PUSH_INIT: begin
        new_ent.weight <= a_ent.weight + b_ent.weight;
        new_ent.node   <= next_node;
        pi             <= hcnt;
        hcnt           <= hcnt + HCNT_W'(1);
      end
      OP_PUSH_CMP: begin
        if (push_stop) next_node <= next_node + NODE_W'(1);
        else           pi <= parent;
      end
      OP_WK_INIT: k <= next_node - NODE_W'(1);
      OP_WK_L: begin
        wk_c <= child_q;
        wk_w <= walk_q;
      end
      OP_WK_R:    k <= k - NODE_W'(1);
      OP_AS_INIT: j <= '0;
      OP_AS_WR:   j <= j + SYM_W'(1);
      default: ;
    endcase
  end

  // Result selection
  always_comb begin
    out_load = 1'b0;
    out_next = '{status: ST_OK, code_bits: '0, code_length: '0};
    case (dp_cmd.op)
      OP_ACCEPT: out_load = !(cmd_item.func == FUNC_BUILD || cmd_item.func == FUNC_READ);
      OP_READ_RESP: begin
        out_load = 1'b1;
        if (codes_ready && code_ok_q) begin
          out_next.code_bits   = code_q.bits;
          out_next.code_length = code_q.len;
        end else begin
          out_next.status = ST_NOCODE;
        end
      end
      OP_EMPTY: begin
        out_load        = 1'b1;
        out_next.status = ST_EMPTY;
      end
      OP_SINGLE:     out_load = 1'b1;
      OP_BUILD_DONE: out_load = 1'b1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp_item <= out_next;
  end

  // Status to controller
  always_comb begin
    sts.out_busy  = rsp_valid && !rsp_ready;
    sts.scan_last = (scan_sym == SYM_W'(SYMBOLS - 1));
    sts.used_zero = (used == '0);
    sts.used_one  = (used == HCNT_W'(1));
    sts.hd_done   = hd_done;
    sts.i_zero    = (hi == '0);
    sts.push_done = push_stop;
    sts.n_one     = (hcnt == HCNT_W'(1));
    sts.wk_last   = (k == NODE_W'(used));
    sts.as_last   = (HCNT_W'(j) == used - HCNT_W'(1));
  end

endmodule

// File: rtl/huffman_code_builder_core.sv
// A frequency write or an idle code gives its result in the cycle after transfer; a
// code read goes through the registered code table read, then the result register. A
// build scans, heapifies, merges, walks the tree and assigns codes. One transfer per
// cycle for writes and idle codes unless the result stalls; a read holds off the next
// transfer until its result is loaded. Reset (rst, synchronous) empties the frequency
// store and codes through valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// Huffman code builder: frequency load, heap-based tree build, code lookup.
// ----------------------------------------------------------------------------
`include "huffman_code_builder_core_macros.svh"

module huffman_code_builder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  hcb_pkg::in_item_t   cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output hcb_pkg::out_item_t  rsp
);
  import hcb_pkg::*;

  cmd_t dp_cmd;
  sts_t sts;
  logic wr_xfer;

  assign wr_xfer = cmd_valid && cmd_ready && (cmd.func == FUNC_WRITE);

  hcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_func  (cmd.func),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .dp_cmd    (dp_cmd)
  );

  hcb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .cmd_item  (cmd),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_item  (rsp),
    .sts       (sts)
  );

  // Checks
  `HCB_ASSERT_NOW(a_ready_no_stall, cmd_ready, !(rsp_valid && !rsp_ready))
  `HCB_ASSERT_NEXT(a_write_resp, wr_xfer, rsp_valid && rsp.status == ST_OK)
  `HCB_ASSERT_NOW(a_nocode_empty, rsp_valid && rsp.status == ST_NOCODE, rsp.code_length == '0)

endmodule
